// ===== hdl/dbop_pkg.sv =====
// Shared types and constants for the delayed beat onset phaser.
// Used by dbop_div, delayed_beat_onset_phaser and the testbench; depends on nothing.
package dbop_pkg;

    localparam int TIME_W            = 48;
    localparam int PHASE_W           = 16;
    localparam int CFG_DATA_W        = 16;
    localparam int DELAY_W           = 3;
    localparam int ONSET_DEPTH_DEF   = 64;
    localparam int BEAT_DEPTH_DEF    = 8;

    // opcode values of an input word
    localparam logic OP_ONSET = 1'b0;
    localparam logic OP_BEAT  = 1'b1;

    // configuration register indexes
    localparam logic CFG_BEAT_DELAY    = 1'b0;
    localparam logic CFG_ONSET_ADVANCE = 1'b1;

    // reset values of the configuration registers
    localparam logic [DELAY_W-1:0]    BEAT_DELAY_RST    = 3'd2;
    localparam logic [CFG_DATA_W-1:0] ONSET_ADVANCE_RST = 16'd0;

    // request into the serial fraction divider
    typedef struct packed {
        logic              go;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    // response from the serial fraction divider
    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== hdl/delayed_beat_onset_phaser.sv =====
// Delayed beat onset phaser: onsets fill a ring, each beat drains it into window phases.
// Onset word: taken while idle, busy stays low. Beat word: busy to read the window (RD_S,
// RD_E, WIN), then per onset a ring read and compare (DR_RD, DR_CMP) plus the serial divider
// when it lies inside the window, and FIN to close; a backward window ends without a drain.
// The 16-step divider sets the rate. Results are one-cycle strobes with no back-pressure.
// rst_n clears pointers, counts, beat valid bits and configuration; no clearing pass.
module delayed_beat_onset_phaser #(
    parameter int ONSET_DEPTH = dbop_pkg::ONSET_DEPTH_DEF,
    parameter int BEAT_DEPTH  = dbop_pkg::BEAT_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           opcode,
    input  logic [dbop_pkg::TIME_W-1:0]    event_time,
    output logic                           result_valid,
    output logic [dbop_pkg::PHASE_W-1:0]   phase,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [dbop_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dbop_pkg::*;

    localparam int OAW = $clog2(ONSET_DEPTH);
    localparam int OCW = $clog2(ONSET_DEPTH + 1);
    localparam int BAW = $clog2(BEAT_DEPTH);
    localparam int BIW = BAW + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD_S   = 3'd1;
    localparam logic [2:0] ST_RD_E   = 3'd2;
    localparam logic [2:0] ST_WIN    = 3'd3;
    localparam logic [2:0] ST_DR_RD  = 3'd4;
    localparam logic [2:0] ST_DR_CMP = 3'd5;
    localparam logic [2:0] ST_DR_DIV = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [DELAY_W-1:0]    beat_delay_reg;
    logic [CFG_DATA_W-1:0] onset_advance_reg;

    logic [OAW-1:0]        owr_ptr_reg, owr_ptr_next;
    logic [OAW-1:0]        ohead_ptr_reg, ohead_ptr_next;
    logic [OCW-1:0]        ocount_reg, ocount_next;
    logic [BAW-1:0]        bwr_ptr_reg, bwr_ptr_next;
    logic [BEAT_DEPTH-1:0] bvld_reg, bvld_next;
    logic                  rvld_reg;
    logic [BAW-1:0]        s_idx_reg, s_idx_next;
    logic [BAW-1:0]        e_idx_reg, e_idx_next;

    logic [TIME_W-1:0]     start_reg, start_next;
    logic [TIME_W-1:0]     end_reg, end_next;
    logic [TIME_W-1:0]     len_reg, len_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [PHASE_W-1:0]    pend_reg, pend_next;

    logic                  res_vld_reg, res_vld_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic [TIME_W-1:0]     adv_ext;
    logic [TIME_W-1:0]     onset_time;
    logic                  o_we;
    logic [OAW-1:0]        o_raddr;
    logic [TIME_W-1:0]     o_rdata;
    logic                  b_we;
    logic [BAW-1:0]        b_raddr;
    logic [TIME_W-1:0]     b_rdata;
    logic [TIME_W-1:0]     b_value;
    logic [BIW-1:0]        delay_ext;
    logic [BIW-1:0]        delay_eff;
    logic [BIW-1:0]        s_sum;
    logic [BIW-1:0]        s_wrap;
    div_req_t              dreq;
    div_rsp_t              drsp;

    // ring pointer increment with wrap
    function automatic logic [OAW-1:0] o_inc(input logic [OAW-1:0] p);
        return (p == OAW'(ONSET_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [BAW-1:0] b_inc(input logic [BAW-1:0] p);
        return (p == BAW'(BEAT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // apply the onset advance
    assign adv_ext    = TIME_W'(onset_advance_reg);
    assign onset_time = (event_time > adv_ext) ? event_time - adv_ext : event_time;

    // window start index: (wr_ptr - delay) mod depth, delay taken mod depth
    assign delay_ext = BIW'(beat_delay_reg);
    assign delay_eff = (delay_ext >= BIW'(BEAT_DEPTH)) ? delay_ext - BIW'(BEAT_DEPTH)
                                                       : delay_ext;
    assign s_sum     = BIW'(bwr_ptr_reg) + BIW'(BEAT_DEPTH) - delay_eff;
    assign s_wrap    = (s_sum >= BIW'(BEAT_DEPTH)) ? s_sum - BIW'(BEAT_DEPTH) : s_sum;

    // beat entries never written read as zero
    assign b_value = rvld_reg ? b_rdata : '0;

    assign o_we    = accept && (opcode == OP_ONSET);
    assign b_we    = accept && (opcode == OP_BEAT);
    assign o_raddr = ohead_ptr_reg;
    assign b_raddr = (state_reg == ST_RD_S) ? s_idx_reg : e_idx_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_delay_reg    <= BEAT_DELAY_RST;
            onset_advance_reg <= ONSET_ADVANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BEAT_DELAY)
            begin
                beat_delay_reg <= cfg_data[DELAY_W-1:0];
            end
            else if (cfg_index == CFG_ONSET_ADVANCE)
            begin
                onset_advance_reg <= cfg_data;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        owr_ptr_next   = owr_ptr_reg;
        ohead_ptr_next = ohead_ptr_reg;
        ocount_next    = ocount_reg;
        bwr_ptr_next   = bwr_ptr_reg;
        bvld_next      = bvld_reg;
        s_idx_next     = s_idx_reg;
        e_idx_next     = e_idx_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        len_next       = len_reg;
        pend_vld_next  = pend_vld_reg;
        pend_next      = pend_reg;
        res_vld_next   = 1'b0;
        phase_next     = phase_reg;
        last_next      = last_reg;
        dreq.go        = 1'b0;
        dreq.num       = o_rdata - start_reg;
        dreq.den       = len_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (o_we)
                begin
                    // push onset, drop oldest when full
                    owr_ptr_next = o_inc(owr_ptr_reg);
                    if (ocount_reg == OCW'(ONSET_DEPTH))
                    begin
                        ohead_ptr_next = o_inc(ohead_ptr_reg);
                    end
                    else
                    begin
                        ocount_next = ocount_reg + 1'b1;
                    end
                end
                else if (b_we)
                begin
                    bvld_next[bwr_ptr_reg] = 1'b1;
                    bwr_ptr_next = b_inc(bwr_ptr_reg);
                    s_idx_next   = s_wrap[BAW-1:0];
                    e_idx_next   = b_inc(s_wrap[BAW-1:0]);
                    state_next   = ST_RD_S;
                end
            end
            ST_RD_S:
            begin
                state_next = ST_RD_E;
            end
            ST_RD_E:
            begin
                start_next = b_value;
                state_next = ST_WIN;
            end
            ST_WIN:
            begin
                end_next = b_value;
                len_next = b_value - start_reg;
                state_next = (b_value < start_reg) ? ST_IDLE : ST_DR_RD;
            end
            ST_DR_RD:
            begin
                state_next = (ocount_reg == '0) ? ST_FIN : ST_DR_CMP;
            end
            ST_DR_CMP:
            begin
                if (o_rdata >= end_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ohead_ptr_next = o_inc(ohead_ptr_reg);
                    ocount_next    = ocount_reg - 1'b1;
                    if (o_rdata >= start_reg)
                    begin
                        dreq.go    = 1'b1;
                        state_next = ST_DR_DIV;
                    end
                    else
                    begin
                        state_next = ST_DR_RD;
                    end
                end
            end
            ST_DR_DIV:
            begin
                if (drsp.done)
                begin
                    // release the held word now that another follows
                    if (pend_vld_reg)
                    begin
                        res_vld_next = 1'b1;
                        phase_next   = pend_reg;
                        last_next    = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_next     = drsp.quot;
                    state_next    = ST_DR_RD;
                end
            end
            ST_FIN:
            begin
                if (pend_vld_reg)
                begin
                    res_vld_next = 1'b1;
                    phase_next   = pend_reg;
                    last_next    = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            owr_ptr_reg   <= '0;
            ohead_ptr_reg <= '0;
            ocount_reg    <= '0;
            bwr_ptr_reg   <= '0;
            bvld_reg      <= '0;
            rvld_reg      <= 1'b0;
            pend_vld_reg  <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            owr_ptr_reg   <= owr_ptr_next;
            ohead_ptr_reg <= ohead_ptr_next;
            ocount_reg    <= ocount_next;
            bwr_ptr_reg   <= bwr_ptr_next;
            bvld_reg      <= bvld_next;
            rvld_reg      <= bvld_reg[b_raddr];
            pend_vld_reg  <= pend_vld_next;
            res_vld_reg   <= res_vld_next;
        end
    end

    // advance payload registers
    always_ff @(posedge clk)
    begin
        s_idx_reg <= s_idx_next;
        e_idx_reg <= e_idx_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        len_reg   <= len_next;
        pend_reg  <= pend_next;
        phase_reg <= phase_next;
        last_reg  <= last_next;
    end

    assign result_valid = res_vld_reg;
    assign phase        = phase_reg;
    assign last         = last_reg;

    dbop_ram #(
        .WIDTH (TIME_W),
        .DEPTH (ONSET_DEPTH)
    ) u_onset_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (owr_ptr_reg),
        .wdata (onset_time),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    dbop_ram #(
        .WIDTH (TIME_W),
        .DEPTH (BEAT_DEPTH)
    ) u_beat_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (bwr_ptr_reg),
        .wdata (event_time),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    dbop_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

endmodule

// ===== hdl/dbop_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the onset ring and the beat ring.
module dbop_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dbop_div.sv =====
// Serial restoring divider: floor(num * 2^16 / den) for num < den, one bit per cycle.
// Depends on dbop_pkg for widths and the request/response structs.
module dbop_div (
    input  logic               clk,
    input  logic               rst_n,
    input  dbop_pkg::div_req_t req,
    output dbop_pkg::div_rsp_t rsp
);
    import dbop_pkg::*;

    localparam int CNT_W = $clog2(PHASE_W);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [TIME_W-1:0]   den_reg, den_next;
    logic [PHASE_W-1:0]  quot_reg, quot_next;
    logic [TIME_W:0]     shifted;
    logic [TIME_W:0]     diff;
    logic                fits;

    // one trial subtraction per cycle
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = req.num;
            den_next = req.den;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            quot_next = {quot_reg[PHASE_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PHASE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // advance the datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== dv/tb_delayed_beat_onset_phaser.sv =====
// Self-checking testbench for delayed_beat_onset_phaser: directed table, then random streams.
// Predicts window phases from its own copy of the onset and beat rings and checks every strobe.
// Depends on dbop_pkg and the delayed_beat_onset_phaser RTL only.
module tb_delayed_beat_onset_phaser;
    import dbop_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_PAUSE = 1300;
    localparam int PHASE_WORDS = 38;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               last;
    } phase_rec_t;

    typedef enum logic [1:0] { R_ONSET, R_BEAT, R_DELAY, R_ADVANCE } row_kind_t;
    typedef enum logic [1:0] { X_PRED, X_NONE, X_ONE } row_exp_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [TIME_W-1:0]  value;
        row_exp_t           exp_kind;
        logic [PHASE_W-1:0] phase;
    } dir_row_t;

    localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

    // Directed words; X_ONE rows carry the single phase (marked last) they must produce
    localparam dir_row_t DIR_TAB [26] = '{
        '{R_ONSET,   48'd0,     X_NONE, 16'd0},
        '{R_BEAT,    48'd1000,  X_NONE, 16'd0},     // fresh beat ring: window of zero length
        '{R_BEAT,    48'd2000,  X_ONE,  16'd0},     // window 0..1000 holds onset 0
        '{R_ONSET,   48'd1500,  X_NONE, 16'd0},
        '{R_ONSET,   48'd1999,  X_NONE, 16'd0},
        '{R_BEAT,    48'd3000,  X_PRED, 16'd0},
        '{R_DELAY,   48'd1,     X_NONE, 16'd0},
        '{R_ONSET,   48'd3500,  X_NONE, 16'd0},
        '{R_BEAT,    48'd4000,  X_ONE,  16'd32768},
        '{R_ADVANCE, 48'd65535, X_NONE, 16'd0},
        '{R_ONSET,   48'd5000,  X_NONE, 16'd0},     // not above the advance: kept as is
        '{R_ONSET,   T_MAX,     X_NONE, 16'd0},
        '{R_ONSET,   48'd65535, X_NONE, 16'd0},     // equal to the advance: kept as is
        '{R_ONSET,   48'd65536, X_NONE, 16'd0},     // one above the advance: becomes 1
        '{R_BEAT,    48'd6000,  X_ONE,  16'd32768},
        '{R_BEAT,    48'd100,   X_NONE, 16'd0},     // window runs backward
        '{R_BEAT,    T_MAX,     X_PRED, 16'd0},
        '{R_ONSET,   48'd10,    X_NONE, 16'd0},
        '{R_BEAT,    T_MAX,     X_NONE, 16'd0},     // empty window drops the onset
        '{R_ADVANCE, 48'd0,     X_NONE, 16'd0},
        '{R_DELAY,   48'd0,     X_NONE, 16'd0},
        '{R_ONSET,   48'd700,   X_NONE, 16'd0},
        '{R_BEAT,    48'd500,   X_PRED, 16'd0},     // delay zero: window from this beat
        '{R_DELAY,   48'd7,     X_NONE, 16'd0},
        '{R_ONSET,   48'd2500,  X_NONE, 16'd0},
        '{R_BEAT,    48'd2200,  X_NONE, 16'd0}      // onset older than the window start
    };

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  opcode       = OP_ONSET;
    logic [TIME_W-1:0]     event_time   = '0;
    logic                  result_valid;
    logic [PHASE_W-1:0]    phase;
    logic                  last;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index    = CFG_BEAT_DELAY;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Predictor state
    logic [TIME_W-1:0]     onset_ring [ONSET_DEPTH_DEF];
    int                    ons_wr     = 0;
    int                    ons_head   = 0;
    int                    ons_cnt    = 0;
    logic [TIME_W-1:0]     beat_ring [BEAT_DEPTH_DEF] = '{default: '0};
    int                    beat_wr    = 0;
    logic [DELAY_W-1:0]    cur_delay   = BEAT_DELAY_RST;
    logic [CFG_DATA_W-1:0] cur_advance = ONSET_ADVANCE_RST;

    phase_rec_t beat_phases[$];
    phase_rec_t pending_phases[$];

    int cycle_cnt    = 0;
    int mismatch_cnt = 0;
    int n_words      = 0;
    int n_beats      = 0;
    int n_results    = 0;
    int n_cfg        = 0;

    delayed_beat_onset_phaser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .event_time   (event_time),
        .result_valid (result_valid),
        .phase        (phase),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    // Abort a hung run
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb_delayed_beat_onset_phaser NOT OK");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
    endtask

    // Restoring division: floor(offs * 2^16 / span), offs < span
    function automatic logic [PHASE_W-1:0] phase_of_onset(input logic [TIME_W-1:0] offs,
                                                          input logic [TIME_W-1:0] span);
        logic [TIME_W:0]    rem;
        logic [PHASE_W-1:0] quo;
        rem = {1'b0, offs};
        quo = '0;
        for (int i = 0; i < PHASE_W; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= {1'b0, span})
            begin
                rem    = rem - {1'b0, span};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Update the ring copies for one word; leave the phases it yields in beat_phases
    function automatic void predict_phases(input logic op, input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] win_lo;
        logic [TIME_W-1:0] win_hi;
        logic [TIME_W-1:0] ons;
        int                s_idx;
        phase_rec_t        held;
        bit                have;
        beat_phases.delete();
        have = 1'b0;
        if (op == OP_ONSET)
        begin
            onset_ring[ons_wr] = (t > {32'd0, cur_advance}) ? t - {32'd0, cur_advance} : t;
            ons_wr = (ons_wr + 1) % ONSET_DEPTH_DEF;
            // drop the oldest onset when the ring is full
            if (ons_cnt >= ONSET_DEPTH_DEF)
                ons_head = (ons_head + 1) % ONSET_DEPTH_DEF;
            else
                ons_cnt++;
            return;
        end
        beat_ring[beat_wr] = t;
        s_idx  = (beat_wr + BEAT_DEPTH_DEF - (int'(cur_delay) % BEAT_DEPTH_DEF)) % BEAT_DEPTH_DEF;
        win_lo = beat_ring[s_idx];
        win_hi = beat_ring[(s_idx + 1) % BEAT_DEPTH_DEF];
        beat_wr = (beat_wr + 1) % BEAT_DEPTH_DEF;
        if (win_hi < win_lo)
            return;
        // drain onsets below the window end; only those at or after its start yield a phase
        while (ons_cnt > 0)
        begin
            ons = onset_ring[ons_head];
            if (ons >= win_hi)
                break;
            if (ons >= win_lo)
            begin
                if (have)
                    beat_phases.push_back(held);
                held.phase = phase_of_onset(ons - win_lo, win_hi - win_lo);
                held.last  = 1'b0;
                have       = 1'b1;
            end
            ons_head = (ons_head + 1) % ONSET_DEPTH_DEF;
            ons_cnt--;
        end
        if (have)
        begin
            held.last = 1'b1;
            beat_phases.push_back(held);
        end
    endfunction

    // Hold start low until every phase is in and the block has settled
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_phases.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_BEAT_DELAY)
            cur_delay = val[DELAY_W-1:0];
        else
            cur_advance = val;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // Send one word, predict it, then idle at random
    task automatic send_word(input logic op, input logic [TIME_W-1:0] t, input int gap_pct,
                             input bit use_pred);
        start      <= 1'b1;
        opcode     <= op;
        event_time <= t;
        do @(posedge clk); while (busy);
        predict_phases(op, t);
        if (use_pred)
            foreach (beat_phases[i]) pending_phases.push_back(beat_phases[i]);
        n_words++;
        if (op == OP_BEAT)
            n_beats++;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic [TIME_W-1:0] rand_time(input int hi_max);
        logic [31:0] hi;
        hi = $urandom_range(0, hi_max);
        return {hi[TIME_W-33:0], $urandom};
    endfunction

    // Check each phase strobe against the oldest expectation
    always @(posedge clk)
    begin : check_phase
        phase_rec_t want;
        if (rst_n && result_valid)
        begin
            n_results++;
            if (pending_phases.size() == 0)
                flag_mismatch($sformatf("unexpected phase %0d last %0b", phase, last));
            else
            begin
                want = pending_phases.pop_front();
                if (phase !== want.phase)
                    flag_mismatch($sformatf("phase %0d, want %0d", phase, want.phase));
                if (last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    initial
    begin : stimulus
        logic [DELAY_W-1:0]    ph_delay [4];
        logic [CFG_DATA_W-1:0] ph_adv [4];
        int                    ph_gap [4];
        logic [TIME_W-1:0]     cursor;
        logic [TIME_W-1:0]     off;
        int                    sent;
        int                    k;
        int                    span;
        int                    pick;
        bit                    raw;
        bit                    burst;

        ph_delay = '{3'd1, 3'd7, 3'($urandom_range(0, 7)), 3'd4};
        ph_adv   = '{16'($urandom), 16'hFFFF, 16'h0000, 16'($urandom)};
        ph_gap   = '{0, 58, 8, 0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (DIR_TAB[r])
        begin
            case (DIR_TAB[r].kind)
                R_DELAY:   write_cfg(CFG_BEAT_DELAY, DIR_TAB[r].value[CFG_DATA_W-1:0]);
                R_ADVANCE: write_cfg(CFG_ONSET_ADVANCE, DIR_TAB[r].value[CFG_DATA_W-1:0]);
                default:
                begin
                    send_word((DIR_TAB[r].kind == R_BEAT) ? OP_BEAT : OP_ONSET,
                              DIR_TAB[r].value, 0, DIR_TAB[r].exp_kind == X_PRED);
                    if (DIR_TAB[r].exp_kind == X_ONE)
                        pending_phases.push_back(phase_rec_t'{DIR_TAB[r].phase, 1'b1});
                end
            endcase
        end

        // Random phases: mostly ordered beat intervals with onsets inside them
        for (int p = 0; p < 4; p++)
        begin
            write_cfg(CFG_BEAT_DELAY, {{(CFG_DATA_W-DELAY_W){1'b0}}, ph_delay[p]});
            write_cfg(CFG_ONSET_ADVANCE, ph_adv[p]);
            cursor = rand_time(16'h3FFF) | 48'h1_0000_0000;
            sent   = 0;
            burst  = (p == 0);
            while (sent < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (burst || pick < 72)
                begin
                    // onsets in time order within one interval, then the closing beat
                    k    = burst ? $urandom_range(66, 72) : $urandom_range(0, 5);
                    span = burst ? $urandom_range(4000, 8000) : $urandom_range(16, 3000);
                    raw  = (pick < 8);
                    off  = '0;
                    for (int i = 0; i < k; i++)
                    begin
                        off = off + $urandom_range(0, span / (k + 1));
                        send_word(OP_ONSET, cursor + off + (raw ? 48'd0 : {32'd0, cur_advance}),
                                  ph_gap[p], 1'b1);
                    end
                    cursor = cursor + span;
                    send_word(OP_BEAT, cursor, ph_gap[p], 1'b1);
                    sent  = sent + k + 1;
                    burst = 1'b0;
                end
                else if (pick < 80)
                begin
                    // beat behind the last one: backward window when the delay is 1
                    send_word(OP_BEAT, cursor - $urandom_range(1, 5000), ph_gap[p], 1'b1);
                    sent++;
                end
                else if (pick < 88)
                begin
                    // repeat the last beat: empty window when the delay is 1
                    send_word(OP_BEAT, cursor, ph_gap[p], 1'b1);
                    sent++;
                end
                else
                begin
                    send_word(1'($urandom), rand_time(16'hFFFF), ph_gap[p], 1'b1);
                    sent++;
                end
            end
        end

        // Drain and settle
        start <= 1'b0;
        while (pending_phases.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);

        $display("Ran %0d words (%0d beats) over %0d register writes, %0d phases out.",
                 n_words, n_beats, n_cfg, n_results);
        $display("Mismatches: %0d", mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("tb_delayed_beat_onset_phaser OK");
        else
            $display("tb_delayed_beat_onset_phaser NOT OK");
        $finish;
    end

endmodule
